/* hdl/pft_pkg.sv */
// ----------------------------------------------------------------------------
// pft_pkg
// shared types and constants of the palette fog tint unit
// ----------------------------------------------------------------------------
package pft_pkg;

	localparam int ENTRY_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FOG_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOG_COLOR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DARKNESS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_MODE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHROUD_TINT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REMAP_SCALE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REMAP_OFFSET = 3'd6;

	localparam logic [7:0]  DARKNESS_RST    = 8'd180;
	localparam logic [23:0] REMAP_SCALE_RST = 24'hFF_FFFF;
	localparam logic        MODE_SHROUD     = 1'b0;
	localparam logic        MODE_REMAP      = 1'b1;

	typedef struct packed {
		logic        fog_enable;
		logic [23:0] fog_color;
		logic [7:0]  darkness;
		logic        tint_mode;
		logic [31:0] shroud_tint;
		logic [23:0] remap_scale;
		logic [23:0] remap_offset;
	} pft_cfg_t;

endpackage

/* hdl/pft_in_if.sv */
// ----------------------------------------------------------------------------
// pft_in_if
// input channel: one palette entry per beat
// ----------------------------------------------------------------------------
interface pft_in_if;
	logic                        valid;
	logic                        ready;
	logic [pft_pkg::ENTRY_W-1:0] palette_entry;

	modport source (output valid, output palette_entry, input ready);
	modport sink (input valid, input palette_entry, output ready);
endinterface

/* hdl/pft_out_if.sv */
// ----------------------------------------------------------------------------
// pft_out_if
// output channel: tinted entry and active flag per beat
// ----------------------------------------------------------------------------
interface pft_out_if;
	logic                        valid;
	logic                        ready;
	logic [pft_pkg::ENTRY_W-1:0] tinted_entry;
	logic                        tint_active;

	modport source (output valid, output tinted_entry, output tint_active, input ready);
	modport sink (input valid, input tinted_entry, input tint_active, output ready);
endinterface

/* hdl/pft_cfg.sv */
// ----------------------------------------------------------------------------
// pft_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module pft_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wen,
	input  logic [pft_pkg::CFG_IDX_W-1:0]    idx,
	input  logic [pft_pkg::CFG_DATA_W-1:0]   wdata,
	output pft_pkg::pft_cfg_t                cfg
);
	import pft_pkg::*;

	pft_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fog_enable   <= 1'b0;
			cfg_q.fog_color    <= '0;
			cfg_q.darkness     <= DARKNESS_RST;
			cfg_q.tint_mode    <= MODE_SHROUD;
			cfg_q.shroud_tint  <= '0;
			cfg_q.remap_scale  <= REMAP_SCALE_RST;
			cfg_q.remap_offset <= '0;
		end else if (wen) begin
			unique case (idx)
				REG_FOG_ENABLE:   cfg_q.fog_enable   <= wdata[0];
				REG_FOG_COLOR:    cfg_q.fog_color    <= wdata[23:0];
				REG_DARKNESS:     cfg_q.darkness     <= wdata[7:0];
				REG_TINT_MODE:    cfg_q.tint_mode    <= wdata[0];
				REG_SHROUD_TINT:  cfg_q.shroud_tint  <= wdata;
				REG_REMAP_SCALE:  cfg_q.remap_scale  <= wdata[23:0];
				REG_REMAP_OFFSET: cfg_q.remap_offset <= wdata[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/palette_fog_tint_unit.sv */
// ----------------------------------------------------------------------------
// palette_fog_tint_unit
// tints rgba5551 palette entries toward fog or shroud colour, or remaps them
// ----------------------------------------------------------------------------
// Takes one palette entry every clock unless stalled and returns one result
// per entry. Stage one forms the 8x8 mixing and the remap products, stage two
// divides by 255, picks target colour and alpha and saturates the remap,
// stage three runs the signed lerp and registers the result for the mode.
// Each stage holds only while its successor is full, so bubbles close up and
// an entry is accepted while a finished result waits. Configuration is taken
// at once on a write and must only be changed while no entries are in flight.
// ----------------------------------------------------------------------------
module palette_fog_tint_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [pft_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pft_pkg::CFG_DATA_W-1:0] cfg_wdata,
	pft_in_if.sink                         pix_in,
	pft_out_if.source                      pix_out
);
	import pft_pkg::*;

	function automatic logic [7:0] div255(input logic [16:0] x);
		logic [16:0] t;
		t = x + 17'd1 + 17'(x[16:8]);
		return t[15:8];
	endfunction

	function automatic logic [4:0] lerp5(input logic [4:0] c, input logic [4:0] f,
		input logic [7:0] a);
		logic signed [5:0]  d;
		logic signed [14:0] p;
		logic signed [14:0] pb;
		logic signed [6:0]  q;
		logic [6:0]         r;
		d  = $signed({1'b0, f}) - $signed({1'b0, c});
		p  = 15'(d) * $signed({7'd0, a});
		pb = p + (p[14] ? 15'sd255 : 15'sd0);
		q  = 7'(pb >>> 8);
		r  = {2'b00, c} + 7'(q);
		return r[4:0];
	endfunction

	function automatic logic [4:0] remap5(input logic [7:0] mn, input logic [12:0] p);
		logic [5:0] v;
		v = {1'b0, mn[7:3]} + {1'b0, p[12:8]};
		return v[5] ? 5'h1F : v[4:0];
	endfunction

	pft_cfg_t cfg;

	pft_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.wen   (cfg_wen),
		.idx   (cfg_idx),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	logic [7:0] sa, nsa;
	logic [7:0] fog_r, fog_g, fog_b, sh_r, sh_g, sh_b;
	logic [4:0] cr, cg, cb;

	assign sa    = cfg.shroud_tint[7:0];
	assign nsa   = 8'd255 - sa;
	assign fog_r = cfg.fog_color[23:16];
	assign fog_g = cfg.fog_color[15:8];
	assign fog_b = cfg.fog_color[7:0];
	assign sh_r  = cfg.shroud_tint[31:24];
	assign sh_g  = cfg.shroud_tint[23:16];
	assign sh_b  = cfg.shroud_tint[15:8];
	assign cr    = pix_in.palette_entry[15:11];
	assign cg    = pix_in.palette_entry[10:6];
	assign cb    = pix_in.palette_entry[5:1];

	// stage enables
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3 = !v_s3 || pix_out.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pix_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pix_in.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1: products
	logic [ENTRY_W-1:0] entry_s1;
	logic [15:0] pf_r_s1, pf_g_s1, pf_b_s1, pd_s1;
	logic [15:0] ps_r_s1, ps_g_s1, ps_b_s1, pa_s1;
	logic [12:0] pm_r_s1, pm_g_s1, pm_b_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			entry_s1 <= pix_in.palette_entry;
			pf_r_s1  <= 16'(fog_r) * 16'(nsa);
			pf_g_s1  <= 16'(fog_g) * 16'(nsa);
			pf_b_s1  <= 16'(fog_b) * 16'(nsa);
			pd_s1    <= 16'(cfg.darkness) * 16'(nsa);
			ps_r_s1  <= 16'(sh_r) * 16'(sa);
			ps_g_s1  <= 16'(sh_g) * 16'(sa);
			ps_b_s1  <= 16'(sh_b) * 16'(sa);
			pa_s1    <= 16'(sa) * 16'(sa);
			pm_r_s1  <= 13'(cr) * 13'(cfg.remap_scale[23:16]);
			pm_g_s1  <= 13'(cg) * 13'(cfg.remap_scale[15:8]);
			pm_b_s1  <= 13'(cb) * 13'(cfg.remap_scale[7:0]);
		end
	end

	// stage 2: mix, target select, remap
	logic [7:0] mix_r, mix_g, mix_b, mix_a;
	logic [7:0] tg_r, tg_g, tg_b, tg_a;

	assign mix_r = div255({1'b0, pf_r_s1} + {1'b0, ps_r_s1});
	assign mix_g = div255({1'b0, pf_g_s1} + {1'b0, ps_g_s1});
	assign mix_b = div255({1'b0, pf_b_s1} + {1'b0, ps_b_s1});
	assign mix_a = div255({1'b0, pd_s1} + {1'b0, pa_s1});

	always_comb begin
		priority if (sa == 8'd0) begin
			tg_r = fog_r;
			tg_g = fog_g;
			tg_b = fog_b;
			tg_a = cfg.darkness;
		end else if (cfg.fog_enable) begin
			tg_r = mix_r;
			tg_g = mix_g;
			tg_b = mix_b;
			tg_a = mix_a;
		end else begin
			tg_r = sh_r;
			tg_g = sh_g;
			tg_b = sh_b;
			tg_a = sa;
		end
	end

	logic [ENTRY_W-1:0] entry_s2, remap_s2;
	logic [4:0]         ft_r_s2, ft_g_s2, ft_b_s2;
	logic [7:0]         a_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			entry_s2 <= entry_s1;
			ft_r_s2  <= tg_r[7:3];
			ft_g_s2  <= tg_g[7:3];
			ft_b_s2  <= tg_b[7:3];
			a_s2     <= tg_a;
			remap_s2 <= {remap5(cfg.remap_offset[23:16], pm_r_s1),
				remap5(cfg.remap_offset[15:8], pm_g_s1),
				remap5(cfg.remap_offset[7:0], pm_b_s1), 1'b1};
		end
	end

	// stage 3: lerp and result select
	logic               ident, active;
	logic [ENTRY_W-1:0] lerp_res, res;

	assign ident = (cfg.remap_scale == REMAP_SCALE_RST) && (cfg.remap_offset == 24'd0);

	always_comb begin
		lerp_res = {lerp5(entry_s2[15:11], ft_r_s2, a_s2),
			lerp5(entry_s2[10:6], ft_g_s2, a_s2),
			lerp5(entry_s2[5:1], ft_b_s2, a_s2), 1'b1};
		unique case (cfg.tint_mode)
			MODE_SHROUD: begin
				active = cfg.fog_enable || (sa != 8'd0);
				res    = !active ? entry_s2 :
					(a_s2 == 8'd255) ? 16'h0001 : lerp_res;
			end
			MODE_REMAP: begin
				active = cfg.fog_enable || !ident;
				res    = active ? remap_s2 : entry_s2;
			end
			default: begin
				active = 1'b0;
				res    = entry_s2;
			end
		endcase
	end

	logic [ENTRY_W-1:0] tinted_s3;
	logic               active_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			tinted_s3 <= res;
			active_s3 <= active;
		end
	end

	assign pix_out.valid        = v_s3;
	assign pix_out.tinted_entry = tinted_s3;
	assign pix_out.tint_active  = active_s3;

`ifndef NO_ASSERTIONS
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !pix_out.ready |=> v_s3 && $stable(tinted_s3) && $stable(active_s3))
		else $error("output beat changed while stalled");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en2 |=> v_s1 && $stable(entry_s1))
		else $error("stage one lost its beat under stall");

	a_alpha_bit: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.tint_active |-> pix_out.tinted_entry[0])
		else $error("tinted entry without alpha bit");

	a_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && !pix_out.tint_active && cfg.tint_mode == MODE_SHROUD
		|-> !cfg.fog_enable && sa == 8'd0)
		else $error("shroud mode inactive with fog or shroud alpha set");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> v_s1)
		else $error("accepted beat missing from stage one");
`endif

endmodule

/* verif/pft_tint_check_pkg.sv */
// ----------------------------------------------------------------------------
// pft_tint_check_pkg
// expected-result tracking for the palette fog tint unit
// ----------------------------------------------------------------------------
// Holds a shadow copy of the tint registers and computes the tinted entry and
// active flag for every accepted palette entry: shroud lerp with fog/shroud
// mixing, full-alpha override, channel remap with saturation, passthrough.
// Results are compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
package pft_tint_check_pkg;

	import pft_pkg::*;

	localparam logic [ENTRY_W-1:0] FULL_ALPHA_ENTRY = 16'h0001;
	localparam int                 ALPHA_FULL       = 255;

	typedef struct packed {
		logic [ENTRY_W-1:0] entry;
		logic               active;
	} tint_beat_t;

	class palette_tint_checker;
		pft_cfg_t   regs;
		tint_beat_t pending_tints[$];
		int         mismatch_cnt;

		function new();
			regs              = '0;
			regs.darkness     = DARKNESS_RST;
			regs.remap_scale  = REMAP_SCALE_RST;
			regs.tint_mode    = MODE_SHROUD;
			mismatch_cnt      = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FOG_ENABLE:   regs.fog_enable   = data[0];
				REG_FOG_COLOR:    regs.fog_color    = data[23:0];
				REG_DARKNESS:     regs.darkness     = data[7:0];
				REG_TINT_MODE:    regs.tint_mode    = data[0];
				REG_SHROUD_TINT:  regs.shroud_tint  = data[31:0];
				REG_REMAP_SCALE:  regs.remap_scale  = data[23:0];
				REG_REMAP_OFFSET: regs.remap_offset = data[23:0];
				default: ;
			endcase
		endfunction

		// signed blend, division truncates toward zero
		static function logic [4:0] lerp5(int c, int f8, int a);
			int fs;
			int r;
			fs = f8 / 8;
			r  = c + ((fs - c) * a) / 256;
			return r[4:0];
		endfunction

		static function logic [4:0] remap5(int c, int mx, int mn);
			int v;
			v = (mn / 8) + ((c * mx) / 256);
			return (v > 31) ? 5'd31 : v[4:0];
		endfunction

		static function int mix255(int x, int y, int sa);
			return (x * (255 - sa) + y * sa) / 255;
		endfunction

		function tint_beat_t tint_entry(logic [ENTRY_W-1:0] e);
			tint_beat_t r;
			int         cr, cg, cb;
			int         fr, fg, fb, a, sa;
			cr       = int'(e[15:11]);
			cg       = int'(e[10:6]);
			cb       = int'(e[5:1]);
			r.entry  = e;
			if (regs.tint_mode == MODE_SHROUD) begin
				sa       = int'(regs.shroud_tint[7:0]);
				fr       = int'(regs.fog_color[23:16]);
				fg       = int'(regs.fog_color[15:8]);
				fb       = int'(regs.fog_color[7:0]);
				a        = int'(regs.darkness);
				r.active = regs.fog_enable || (sa != 0);
				if (sa != 0) begin
					if (regs.fog_enable) begin
						fr = mix255(fr, int'(regs.shroud_tint[31:24]), sa);
						fg = mix255(fg, int'(regs.shroud_tint[23:16]), sa);
						fb = mix255(fb, int'(regs.shroud_tint[15:8]), sa);
						a  = mix255(int'(regs.darkness), sa, sa);
					end else begin
						fr = int'(regs.shroud_tint[31:24]);
						fg = int'(regs.shroud_tint[23:16]);
						fb = int'(regs.shroud_tint[15:8]);
						a  = sa;
					end
				end
				if (r.active) begin
					if (a == ALPHA_FULL)
						r.entry = FULL_ALPHA_ENTRY;
					else
						r.entry = {lerp5(cr, fr, a), lerp5(cg, fg, a), lerp5(cb, fb, a), 1'b1};
				end
			end else begin
				r.active = regs.fog_enable ||
					!((regs.remap_scale == REMAP_SCALE_RST) && (regs.remap_offset == '0));
				if (r.active)
					r.entry = {
						remap5(cr, int'(regs.remap_scale[23:16]), int'(regs.remap_offset[23:16])),
						remap5(cg, int'(regs.remap_scale[15:8]), int'(regs.remap_offset[15:8])),
						remap5(cb, int'(regs.remap_scale[7:0]), int'(regs.remap_offset[7:0])),
						1'b1};
			end
			return r;
		endfunction

		function void note_entry(logic [ENTRY_W-1:0] e);
			pending_tints.push_back(tint_entry(e));
		endfunction

		function void check_tint(logic [ENTRY_W-1:0] entry, logic active);
			tint_beat_t exp_beat;
			if (pending_tints.size() == 0) begin
				$display("%0t unexpected beat: expected none, actual entry %h active %b",
					$time, entry, active);
				mismatch_cnt++;
			end else begin
				exp_beat = pending_tints.pop_front();
				if (entry !== exp_beat.entry) begin
					$display("%0t tinted_entry mismatch: expected %h, actual %h",
						$time, exp_beat.entry, entry);
					mismatch_cnt++;
				end
				if (active !== exp_beat.active) begin
					$display("%0t tint_active mismatch: expected %b, actual %b",
						$time, exp_beat.active, active);
					mismatch_cnt++;
				end
			end
		endfunction

		function int outstanding();
			return pending_tints.size();
		endfunction
	endclass

endpackage

/* verif/palette_fog_tint_unit_test.sv */
// ----------------------------------------------------------------------------
// palette_fog_tint_unit_test
// self-checking bench for the palette fog tint unit
// ----------------------------------------------------------------------------
// Streams palette entries through the unit under a series of register
// settings: a directed pass over edge entries, fog, shroud, mixed fog and
// shroud, full alpha, remap and passthrough, then random settings with random
// entries. Sender and receiver idle at various rates, and one phase holds the
// output off long enough to back the pipeline up into the input.
// ----------------------------------------------------------------------------
module palette_fog_tint_unit_test;

	import pft_pkg::*;
	import pft_tint_check_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int IDLE_LIMIT    = 3000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 200;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 110;
	localparam int PRESSURE_PHASE = 4;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	pft_in_if  pix_in();
	pft_out_if pix_out();

	palette_fog_tint_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_in),
		.pix_out   (pix_out)
	);

	palette_tint_checker tint_chk = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	always #4 clk = ~clk;

	// receiver ready, with optional long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			pix_out.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_out.valid && pix_out.ready)
				tint_chk.check_tint(pix_out.tinted_entry, pix_out.tint_active);
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles == IDLE_LIMIT) begin
				$display("%0t watchdog: no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic send_entry(input logic [ENTRY_W-1:0] e);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in.valid         <= 1'b1;
		pix_in.palette_entry <= e;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
		tint_chk.note_entry(e);
	endtask

	task automatic drain();
		@(negedge clk);
		pix_in.valid <= 1'b0;
		while (tint_chk.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// upper bits above the register width carry junk
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value,
		input int w);
		logic [CFG_DATA_W-1:0] data;
		data = (w >= CFG_DATA_W) ? value : (($urandom << w) | value);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		tint_chk.set_reg(idx, data);
	endtask

	task automatic apply_cfg(input logic fe, input logic [23:0] fc, input logic [7:0] dk,
		input logic md, input logic [31:0] st, input logic [23:0] rs, input logic [23:0] ro);
		write_reg(REG_FOG_ENABLE, 32'(fe), 1);
		write_reg(REG_FOG_COLOR, 32'(fc), 24);
		write_reg(REG_DARKNESS, 32'(dk), 8);
		write_reg(REG_TINT_MODE, 32'(md), 1);
		write_reg(REG_SHROUD_TINT, st, 32);
		write_reg(REG_REMAP_SCALE, 32'(rs), 24);
		write_reg(REG_REMAP_OFFSET, 32'(ro), 24);
		write_reg(REG_NONE, $urandom, 32);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [23:0] pick24();
		case ($urandom_range(3))
			0:       return 24'h00_0000;
			1:       return 24'hFF_FFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_setting();
		logic [7:0]  dk;
		logic [7:0]  sa;
		logic [23:0] rs;
		logic [23:0] ro;
		case ($urandom_range(3))
			0:       dk = 8'd0;
			1:       dk = 8'd255;
			default: dk = 8'($urandom);
		endcase
		case ($urandom_range(5))
			0, 1:    sa = 8'd0;
			2:       sa = 8'd255;
			default: sa = 8'($urandom_range(254, 1));
		endcase
		if ($urandom_range(2) == 0) begin
			rs = REMAP_SCALE_RST;
			ro = '0;
		end else begin
			rs = pick24();
			ro = pick24();
		end
		apply_cfg(1'($urandom_range(1)), pick24(), dk, 1'($urandom_range(1)),
			{pick24(), sa}, rs, ro);
	endtask

	function automatic logic [ENTRY_W-1:0] random_entry();
		case ($urandom_range(7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		pix_in.valid         = 1'b0;
		pix_in.palette_entry = '0;
		pix_out.ready        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: shroud mode, nothing active, entries pass through
		send_entry(16'h0000);
		send_entry(16'hFFFF);
		send_entry(16'hAAAA);
		send_entry(16'h5555);

		// fog only, high darkness, lerp both up and down
		drain();
		apply_cfg(1'b1, 24'h00FF80, 8'd254, MODE_SHROUD, 32'h0, REMAP_SCALE_RST, 24'h0);
		send_entry(16'h0000);
		send_entry(16'hFFFF);
		send_entry(16'hF801);
		send_entry(16'h07C0);
		send_entry(16'h003E);

		// fog at full alpha
		drain();
		apply_cfg(1'b1, 24'hFFFFFF, 8'd255, MODE_SHROUD, 32'h0, REMAP_SCALE_RST, 24'h0);
		send_entry(16'hFFFF);
		send_entry(16'h1234);

		// shroud only, then shroud at full alpha
		drain();
		apply_cfg(1'b0, 24'h0, 8'd0, MODE_SHROUD, 32'h12345680, REMAP_SCALE_RST, 24'h0);
		send_entry(16'hFFFF);
		send_entry(16'h0001);
		drain();
		apply_cfg(1'b0, 24'h0, 8'd0, MODE_SHROUD, 32'hFFFFFFFF, REMAP_SCALE_RST, 24'h0);
		send_entry(16'h8421);

		// fog and shroud mixed
		drain();
		apply_cfg(1'b1, 24'h102030, 8'd100, MODE_SHROUD, 32'hF0E0D040, REMAP_SCALE_RST,
			24'h0);
		send_entry(16'hFFFE);
		send_entry(16'h4210);

		// fog with identity remap still remaps
		drain();
		apply_cfg(1'b1, 24'hABCDEF, 8'd77, MODE_REMAP, 32'h0, REMAP_SCALE_RST, 24'h0);
		send_entry(16'hFFFF);
		send_entry(16'h0000);

		// remap with zero scale and full offset, held at the top value
		drain();
		apply_cfg(1'b0, 24'h0, 8'd0, MODE_REMAP, 32'h0, 24'h000000, 24'hFFFFFF);
		send_entry(16'h0000);
		send_entry(16'hFFFF);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			random_setting();
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 80;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 80;
				end
				default: begin
					send_idle_pct  = 32;
					recv_stall_pct = 32;
				end
			endcase
			if (p == PRESSURE_PHASE)
				hold_left = HOLD_CYCLES;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_entry(random_entry());
		end

		drain();
		if (tint_chk.mismatch_cnt == 0 && tint_chk.outstanding() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* palette_fog_tint_unit.f */
hdl/pft_pkg.sv
hdl/pft_in_if.sv
hdl/pft_out_if.sv
hdl/pft_cfg.sv
hdl/palette_fog_tint_unit.sv
verif/pft_tint_check_pkg.sv
verif/palette_fog_tint_unit_test.sv
